>>> sv/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Types, constants and helpers shared by the Euler-to-rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package e2r_pkg;

  localparam int unsigned AngleBitsDef = 16;
  localparam int unsigned CoefBitsDef  = 16;
  localparam int unsigned TransBits    = 24;
  localparam int unsigned CordicIters  = 30;
  localparam int unsigned WorkFrac     = 30;
  localparam int unsigned WorkBits     = 34;
  localparam int unsigned PhaseBits    = 33;

  localparam logic signed [WorkBits-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [WorkBits-1:0] work_t;

  typedef struct packed {
    logic signed [TransBits-1:0] trans_x;
    logic signed [TransBits-1:0] trans_y;
    logic signed [TransBits-1:0] trans_z;
    logic signed [AngleBitsDef-1:0] roll_angle;
    logic signed [AngleBitsDef-1:0] pitch_angle;
    logic signed [AngleBitsDef-1:0] yaw_angle;
  } e2r_in_t;

  typedef struct packed {
    logic signed [CoefBitsDef-1:0] m00;
    logic signed [CoefBitsDef-1:0] m01;
    logic signed [CoefBitsDef-1:0] m02;
    logic signed [CoefBitsDef-1:0] m10;
    logic signed [CoefBitsDef-1:0] m11;
    logic signed [CoefBitsDef-1:0] m12;
    logic signed [CoefBitsDef-1:0] m20;
    logic signed [CoefBitsDef-1:0] m21;
    logic signed [CoefBitsDef-1:0] m22;
    logic signed [TransBits-1:0] out_x;
    logic signed [TransBits-1:0] out_y;
    logic signed [TransBits-1:0] out_z;
  } e2r_out_t;

  typedef struct packed {
    logic signed [TransBits-1:0] x;
    logic signed [TransBits-1:0] y;
    logic signed [TransBits-1:0] z;
  } trans_t;

  function automatic logic [PhaseBits-1:0] atan_turns(input int unsigned idx);
    logic [PhaseBits-1:0] r;
    unique case (idx)
      0: r = 33'd536870912;  1: r = 33'd316933406;  2: r = 33'd167458907;
      3: r = 33'd85004756;   4: r = 33'd42667331;   5: r = 33'd21354465;
      6: r = 33'd10679838;   7: r = 33'd5340245;    8: r = 33'd2670163;
      9: r = 33'd1335087;    10: r = 33'd667544;    11: r = 33'd333772;
      12: r = 33'd166886;    13: r = 33'd83443;     14: r = 33'd41722;
      15: r = 33'd20861;     16: r = 33'd10430;     17: r = 33'd5215;
      18: r = 33'd2608;      19: r = 33'd1304;      20: r = 33'd652;
      21: r = 33'd326;       22: r = 33'd163;       23: r = 33'd81;
      24: r = 33'd41;        25: r = 33'd20;        26: r = 33'd10;
      27: r = 33'd5;         28: r = 33'd3;         29: r = 33'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Pose to ZYX rotation matrix: CORDIC sine and cosine, products, rounding.
// ----------------------------------------------------------------------------
//  Channel | Handshake         | Payload
//  in      | in_valid_i/_ready_o | in_data_i  (e2r_in_t)
//  out     | out_valid_o/_ready_i | out_data_o (e2r_out_t)
//
// One pose per cycle while the output is not stalled. The path holds 35
// register stages: 31 CORDIC stages, three product stages and the output
// register. The whole pipeline advances when the output register is empty
// or taken, so a stall freezes every stage in place. Reset clears the
// valid bits only.
`default_nettype none
module euler_to_rotation_matrix
  import e2r_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = AngleBitsDef,
  parameter int unsigned COEF_BITS  = CoefBitsDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire e2r_pkg::e2r_in_t  in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output e2r_pkg::e2r_out_t out_data_o
);

  logic en;
  logic [ANGLE_BITS-1:0] ang [3];
  trans_t tin, tc, tm;
  work_t s [3];
  work_t c [3];
  logic cv, mv;
  logic signed [COEF_BITS-1:0] m [9];

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign ang[0] = ANGLE_BITS'(in_data_i.roll_angle);
  assign ang[1] = ANGLE_BITS'(in_data_i.pitch_angle);
  assign ang[2] = ANGLE_BITS'(in_data_i.yaw_angle);
  assign tin = '{x: in_data_i.trans_x, y: in_data_i.trans_y, z: in_data_i.trans_z};

  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .ang_i(ang),
    .trans_i(tin), .valid_o(cv), .sin_o(s), .cos_o(c), .trans_o(tc)
  );

  e2r_matrix #(.COEF_BITS(COEF_BITS)) u_matrix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cv), .sin_i(s), .cos_i(c),
    .trans_i(tc), .valid_o(mv), .m_o(m), .trans_o(tm)
  );

  logic vld_q;
  e2r_out_t dat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= mv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dat_q.m00 <= 16'(m[0]); dat_q.m01 <= 16'(m[1]); dat_q.m02 <= 16'(m[2]);
      dat_q.m10 <= 16'(m[3]); dat_q.m11 <= 16'(m[4]); dat_q.m12 <= 16'(m[5]);
      dat_q.m20 <= 16'(m[6]); dat_q.m21 <= 16'(m[7]); dat_q.m22 <= 16'(m[8]);
      dat_q.out_x <= tm.x; dat_q.out_y <= tm.y; dat_q.out_z <= tm.z;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = dat_q;

endmodule
`default_nettype wire

>>> sv/e2r_cordic.sv
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined rotation-mode CORDIC: one iteration per stage, sine and cosine
// in Q4.30 for each of three angles at once, with a quadrant fold ahead.
// ----------------------------------------------------------------------------
`default_nettype none
module e2r_cordic
  import e2r_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = AngleBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire logic [ANGLE_BITS-1:0]   ang_i [3],
  input  wire e2r_pkg::trans_t         trans_i,
  output logic                         valid_o,
  output e2r_pkg::work_t               sin_o [3],
  output e2r_pkg::work_t               cos_o [3],
  output e2r_pkg::trans_t              trans_o
);

  localparam int unsigned N = CordicIters;

  work_t               x_q [N+1][3];
  work_t               y_q [N+1][3];
  logic signed [PhaseBits-1:0] z_q [N+1][3];
  logic                flip_q [N+1][3];
  logic                vld_q [N+1];
  trans_t              tr_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= N; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s <= N; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tr_q[0] <= trans_i;
      for (int a = 0; a < 3; a++) begin
        logic [31:0] ph;
        logic signed [PhaseBits-1:0] z;
        logic f;
        ph = 32'(ang_i[a]) << (32 - ANGLE_BITS);
        z  = PhaseBits'($signed(ph));
        f  = 1'b0;
        if (z > (33'sd1 <<< 30)) begin
          z = z - (33'sd1 <<< 31);
          f = 1'b1;
        end else if (z < -(33'sd1 <<< 30)) begin
          z = z + (33'sd1 <<< 31);
          f = 1'b1;
        end
        flip_q[0][a] <= f;
        z_q[0][a] <= z;
        x_q[0][a] <= CordicGain;
        y_q[0][a] <= '0;
      end
      for (int s = 0; s < N; s++) begin
        tr_q[s+1] <= tr_q[s];
        for (int a = 0; a < 3; a++) begin
          flip_q[s+1][a] <= flip_q[s][a];
          if (!z_q[s][a][PhaseBits-1]) begin
            x_q[s+1][a] <= x_q[s][a] - (y_q[s][a] >>> s);
            y_q[s+1][a] <= y_q[s][a] + (x_q[s][a] >>> s);
            z_q[s+1][a] <= z_q[s][a] - $signed(atan_turns(s));
          end else begin
            x_q[s+1][a] <= x_q[s][a] + (y_q[s][a] >>> s);
            y_q[s+1][a] <= y_q[s][a] - (x_q[s][a] >>> s);
            z_q[s+1][a] <= z_q[s][a] + $signed(atan_turns(s));
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sin_o[a] = flip_q[N][a] ? -y_q[N][a] : y_q[N][a];
      cos_o[a] = flip_q[N][a] ? -x_q[N][a] : x_q[N][a];
    end
  end
  assign valid_o = vld_q[N];
  assign trans_o = tr_q[N];

endmodule
`default_nettype wire

>>> sv/e2r_matrix.sv
// ----------------------------------------------------------------------------
// e2r_matrix
// Builds the nine entries of Rz*Ry*Rx from the sines and cosines over three
// product stages, then rounds and saturates each entry to the coefficient.
// ----------------------------------------------------------------------------
`default_nettype none
module e2r_matrix
  import e2r_pkg::*;
#(
  parameter int unsigned COEF_BITS = CoefBitsDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         en_i,
  input  wire                         valid_i,
  input  wire e2r_pkg::work_t         sin_i [3],
  input  wire e2r_pkg::work_t         cos_i [3],
  input  wire e2r_pkg::trans_t        trans_i,
  output logic                        valid_o,
  output logic signed [COEF_BITS-1:0] m_o [9],
  output e2r_pkg::trans_t             trans_o
);

  localparam int unsigned Sh = 32 - COEF_BITS;
  localparam int unsigned PB = 2 * WorkBits;

  function automatic work_t mulq(input work_t a, input work_t b);
    logic signed [PB-1:0] p;
    p = (PB'(a) * PB'(b)) + (PB'(1) <<< (WorkFrac - 1));
    return work_t'(p >>> WorkFrac);
  endfunction

  function automatic logic signed [COEF_BITS-1:0] to_coef(input work_t v);
    work_t r;
    work_t lim;
    lim = work_t'(1) <<< (COEF_BITS - 2);
    r = (Sh > 0) ? ((v + (work_t'(1) <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh) : v;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[COEF_BITS-1:0];
  endfunction

  // Stage A: first-level products. Stage B: second-level products.
  // Stage C: sums, rounding and saturation.
  work_t sa_q, ca_q, sb_q, cb_q, sg_q, cg_q, sasb_q, casb_q;
  work_t p_q [11];
  logic signed [COEF_BITS-1:0] m_q [9];
  logic  [2:0] vld_q;
  trans_t tr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= sin_i[0];  ca_q <= cos_i[0];
      sb_q   <= sin_i[1];  cb_q <= cos_i[1];
      sg_q   <= sin_i[2];  cg_q <= cos_i[2];
      sasb_q <= mulq(sin_i[0], sin_i[1]);
      casb_q <= mulq(cos_i[0], sin_i[1]);
      tr_q[0] <= trans_i;

      p_q[0]  <= mulq(cb_q, cg_q);
      p_q[1]  <= mulq(sasb_q, cg_q);
      p_q[2]  <= mulq(ca_q, sg_q);
      p_q[3]  <= mulq(casb_q, cg_q);
      p_q[4]  <= mulq(sa_q, sg_q);
      p_q[5]  <= mulq(cb_q, sg_q);
      p_q[6]  <= mulq(sasb_q, sg_q);
      p_q[7]  <= mulq(ca_q, cg_q);
      p_q[8]  <= mulq(casb_q, sg_q);
      p_q[9]  <= mulq(sa_q, cg_q);
      p_q[10] <= -sb_q;
      m_q[7]  <= to_coef(mulq(sa_q, cb_q));
      m_q[8]  <= to_coef(mulq(ca_q, cb_q));
      tr_q[1] <= tr_q[0];

      m_q[0] <= to_coef(p_q[0]);
      m_q[1] <= to_coef(p_q[1] - p_q[2]);
      m_q[2] <= to_coef(p_q[3] + p_q[4]);
      m_q[3] <= to_coef(p_q[5]);
      m_q[4] <= to_coef(p_q[6] + p_q[7]);
      m_q[5] <= to_coef(p_q[8] - p_q[9]);
      m_q[6] <= to_coef(p_q[10]);
      tr_q[2] <= tr_q[1];
    end
  end

  // Entries 7 and 8 are final one stage early, so they take a second stage.
  logic signed [COEF_BITS-1:0] m78_q [2];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m78_q[0] <= m_q[7];
      m78_q[1] <= m_q[8];
    end
  end

  always_comb begin
    for (int k = 0; k < 7; k++) m_o[k] = m_q[k];
    m_o[7] = m78_q[0];
    m_o[8] = m78_q[1];
  end
  assign valid_o = vld_q[2];
  assign trans_o = tr_q[2];

endmodule
`default_nettype wire

>>> sv/e2r_checker.sv
// ----------------------------------------------------------------------------
// e2r_checker
// Port-level checks for the Euler-to-rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module e2r_checker
  import e2r_pkg::*;
(
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready_o,
  input wire out_valid_o,
  input wire out_ready_i,
  input wire e2r_pkg::e2r_out_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.m00 <= 16'sd16384 && out_data_o.m00 >= -16'sd16384)
    else $error("entry beyond unit range");

endmodule

bind euler_to_rotation_matrix e2r_checker u_e2r_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire

>>> sim/tb_euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix
// Self-checking testbench for the pose to rotation matrix pipeline. Directed
// angle extremes and quadrant boundaries come first, then a drain pause, then
// random poses with random gaps on both channels and a long output stall. Every
// output beat is compared field by field with a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_euler_to_rotation_matrix;
  import e2r_pkg::*;

  localparam int Latency = 34;
  localparam int WatchdogLimit = 4000;
  localparam int RandomPoses = 1530;

  typedef longint signed s64_t;

  s64_t arctan_step[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1};

  class matrix_scoreboard;
    e2r_out_t pending_matrices[$];
    int errors;
    int checked;

    function automatic void sin_cos(logic signed [15:0] ang, output s64_t sn,
                                    output s64_t cs);
      s64_t z, x, y, dx, dy;
      bit flip;
      z = s64_t'(ang) <<< 16;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > (s64_t'(1) <<< 30)) begin
        z -= s64_t'(1) <<< 31;
        flip = 1;
      end else if (z < -(s64_t'(1) <<< 30)) begin
        z += s64_t'(1) <<< 31;
        flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_step[i];
        end else begin
          x += dx; y -= dy; z += arctan_step[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      sn = y;
      cs = x;
    endfunction

    function automatic s64_t qmul(s64_t a, s64_t b);
      return (a * b + (s64_t'(1) <<< 29)) >>> 30;
    endfunction

    function automatic logic [15:0] to_q14(s64_t v);
      s64_t r;
      r = (v + (s64_t'(1) <<< 15)) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
    endfunction

    function automatic void note_pose(e2r_in_t p);
      s64_t sa, ca, sb, cb, sg, cg, sasb, casb;
      e2r_out_t m;
      sin_cos(p.roll_angle, sa, ca);
      sin_cos(p.pitch_angle, sb, cb);
      sin_cos(p.yaw_angle, sg, cg);
      sasb = qmul(sa, sb);
      casb = qmul(ca, sb);
      m.m00 = to_q14(qmul(cb, cg));
      m.m01 = to_q14(qmul(sasb, cg) - qmul(ca, sg));
      m.m02 = to_q14(qmul(casb, cg) + qmul(sa, sg));
      m.m10 = to_q14(qmul(cb, sg));
      m.m11 = to_q14(qmul(sasb, sg) + qmul(ca, cg));
      m.m12 = to_q14(qmul(casb, sg) - qmul(sa, cg));
      m.m20 = to_q14(-sb);
      m.m21 = to_q14(qmul(sa, cb));
      m.m22 = to_q14(qmul(ca, cb));
      m.out_x = p.trans_x;
      m.out_y = p.trans_y;
      m.out_z = p.trans_z;
      pending_matrices.push_back(m);
    endfunction

    function automatic void check_matrix(e2r_out_t got);
      e2r_out_t w;
      checked++;
      if (pending_matrices.size() == 0) begin
        $error("output beat with no pose outstanding");
        errors++;
        return;
      end
      w = pending_matrices.pop_front();
      if (got.m00 !== w.m00) begin $error("m00 exp %0d got %0d", w.m00, got.m00); errors++; end
      if (got.m01 !== w.m01) begin $error("m01 exp %0d got %0d", w.m01, got.m01); errors++; end
      if (got.m02 !== w.m02) begin $error("m02 exp %0d got %0d", w.m02, got.m02); errors++; end
      if (got.m10 !== w.m10) begin $error("m10 exp %0d got %0d", w.m10, got.m10); errors++; end
      if (got.m11 !== w.m11) begin $error("m11 exp %0d got %0d", w.m11, got.m11); errors++; end
      if (got.m12 !== w.m12) begin $error("m12 exp %0d got %0d", w.m12, got.m12); errors++; end
      if (got.m20 !== w.m20) begin $error("m20 exp %0d got %0d", w.m20, got.m20); errors++; end
      if (got.m21 !== w.m21) begin $error("m21 exp %0d got %0d", w.m21, got.m21); errors++; end
      if (got.m22 !== w.m22) begin $error("m22 exp %0d got %0d", w.m22, got.m22); errors++; end
      if (got.out_x !== w.out_x) begin
        $error("out_x exp %0d got %0d", w.out_x, got.out_x); errors++;
      end
      if (got.out_y !== w.out_y) begin
        $error("out_y exp %0d got %0d", w.out_y, got.out_y); errors++;
      end
      if (got.out_z !== w.out_z) begin
        $error("out_z exp %0d got %0d", w.out_z, got.out_z); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  e2r_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  e2r_out_t out_data_o;

  matrix_scoreboard board = new();
  int idle_cycles = 0;
  int poses_sent = 0;
  bit long_stall_req = 0;
  bit long_stall_done = 0;

  always #4 clk_i = ~clk_i;

  euler_to_rotation_matrix dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_pose(in_data_i);
      if (out_valid_o && out_ready_i) board.check_matrix(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("euler_to_rotation_matrix: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random holds, plus one long hold so the pipeline backs up.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_stall_req && !long_stall_done) begin
        out_ready_i <= 1'b0;
        repeat (3 * Latency) @(negedge clk_i);
        long_stall_done = 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  task automatic send_pose(e2r_in_t p, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    poses_sent++;
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] special[10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000,
                                 16'h4001, 16'hBFFF, 16'h0001, 16'hFFFF, 16'h2000};
    if ($urandom_range(0, 7) == 0) return special[$urandom_range(0, 9)];
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    e2r_in_t p;
    logic [15:0] dir_angles[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000,
                                   16'hC000, 16'h4001, 16'hBFFF, 16'hFFFF};
    int waited;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 8; i++) begin
      p.trans_x = (i % 2) ? 24'h7FFFFF : 24'h800000;
      p.trans_y = (i % 2) ? 24'h800000 : 24'h7FFFFF;
      p.trans_z = (i % 3 == 0) ? 24'h000000 : 24'hFFFFFF;
      p.roll_angle = dir_angles[i];
      p.pitch_angle = dir_angles[(i + 3) % 8];
      p.yaw_angle = dir_angles[(i + 5) % 8];
      send_pose(p, 0);
    end
    for (int i = 0; i < 8; i++) begin
      p = '0;
      p.roll_angle = dir_angles[i];
      p.pitch_angle = dir_angles[i];
      p.yaw_angle = dir_angles[i];
      send_pose(p, 1);
    end

    // Drain pause: hold the input until all outstanding poses are out.
    in_valid_i <= 1'b0;
    while (board.pending_matrices.size() != 0) @(negedge clk_i);

    for (int n = 0; n < RandomPoses; n++) begin
      p.trans_x = 24'($urandom());
      p.trans_y = 24'($urandom());
      p.trans_z = 24'($urandom());
      p.roll_angle = pick_angle();
      p.pitch_angle = pick_angle();
      p.yaw_angle = pick_angle();
      if (n == 400) long_stall_req = 1;
      send_pose(p, (n >= 400 && n < 480) || (n % 200 > 150));
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (board.pending_matrices.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (Latency + 10) @(negedge clk_i);
    $display("Sent %0d poses (angle extremes, quarter turns, random), checked %0d beats.",
             poses_sent, board.checked);
    if (board.errors == 0 && board.pending_matrices.size() == 0) begin
      $display("euler_to_rotation_matrix: match");
    end else begin
      $display("euler_to_rotation_matrix: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
